@@ rtl/core/atk_pkg.sv @@
// Package for the ADC-to-temperature keystroke block.
// Holds table geometry, key codes, sequencer states and shared structs.
`default_nettype none
package atk_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;

    localparam int DIV_W = 11;   // dividend / quotient width
    localparam int DSR_W = 7;    // divisor / remainder width
    localparam int CNT_W = 4;    // divider step counter

    localparam logic [5:0] KEY_REL   = 6'd0;
    localparam logic [5:0] KEY_ONE   = 6'd30;
    localparam logic [5:0] KEY_ZERO  = 6'd39;
    localparam logic [5:0] KEY_ENTER = 6'd40;
    localparam logic [5:0] KEY_DASH  = 6'd45;
    localparam logic [5:0] KEY_DOT   = 6'd55;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_RAW     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SEL_RD,
        ST_SEL,
        ST_Q1_WAIT,
        ST_TEN,
        ST_TEN_WAIT,
        ST_DIG,
        ST_EM_LEAD,
        ST_EM_NEG,
        ST_EM_DIG,
        ST_EM_DOT,
        ST_EM_TEN,
        ST_EM_ENT
    } state_t;

    typedef struct packed {
        logic [9:0] bp;
        logic [7:0] temp;
        logic [6:0] step;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [5:0] digit_key(input logic [3:0] d);
        digit_key = (d == 4'd0) ? KEY_ZERO : 6'(KEY_ONE - 6'd1 + {2'b00, d});
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/atk_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on atk_pkg for widths and request/response structs.
`default_nettype none
module atk_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire atk_pkg::div_req_t req,
    output atk_pkg::div_rsp_t      rsp
);
    logic [atk_pkg::DIV_W-1:0] quo_reg;
    logic [atk_pkg::DSR_W-1:0] rem_reg;
    logic [atk_pkg::DSR_W-1:0] dsr_reg;
    logic [atk_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [atk_pkg::DSR_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[atk_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == atk_pkg::CNT_W'(atk_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_reg <= {quo_reg[atk_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? atk_pkg::DSR_W'(trial - {1'b0, dsr_reg})
                            : trial[atk_pkg::DSR_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

@@ rtl/core/atk_table.sv @@
// Calibration table memory: one write port, one registered read port.
// Depends on atk_pkg for depth and entry layout.
`default_nettype none
module atk_table (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [atk_pkg::ADDR_W-1:0] wr_addr,
    input  wire atk_pkg::entry_t            wr_data,
    input  wire logic [atk_pkg::ADDR_W-1:0] rd_addr,
    output atk_pkg::entry_t                 rd_data
);
    atk_pkg::entry_t mem [atk_pkg::TABLE_DEPTH];
    atk_pkg::entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule
`default_nettype wire

@@ rtl/core/adc_to_temperature_keystrokes.sv @@
// Top level of the ADC-to-temperature keystroke block.
// Uses atk_pkg, atk_table (calibration memory) and atk_div (shared divider).
//
// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | tdata: slot, breakpoint, temperature, step, sample
//         |     |                    | tuser: func (0 load, 1 convert)
// m_*     | out | m_tvalid/m_tready  | tdata: key_code; tlast: last_key
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load word is written to the table when it is accepted. A convert word
// searches the table with a read state and a compare state per entry, reads the
// chosen entry, then runs the shared divider twice (start, eleven quotient bits,
// done) for the segment quotient and the tenths digit, and splits the integer
// into decimal digits at one digit per cycle; raw mode skips the search and the
// divider. Codes then go out at one per cycle when the output is not stalled.
// s_tready is high only while the sequencer is idle; a stalled output holds
// the sequencer. Reset returns to idle with one table entry in use, raw off.
`default_nettype none
module adc_to_temperature_keystrokes (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // slot[4:0] bp[14:5] temp[22:15] step[29:23] sample[39:30]
    input  wire logic [0:0]  s_tuser,  // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // key_code[5:0], zero [7:6]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);
    localparam int AW = atk_pkg::ADDR_W;
    localparam int IW = atk_pkg::IDX_W;

    atk_pkg::state_t state_reg, state_next;

    logic [5:0]        entries_reg;
    logic              raw_cfg_reg;
    logic              raw_reg;
    logic [9:0]        sample_reg;
    logic [IW-1:0]     idx_reg;
    logic              below_reg;
    logic [7:0]        temp_reg;
    logic [6:0]        step_reg;
    logic [6:0]        rem1_reg;
    logic [3:0]        tenths_reg;
    logic [10:0]       mag_reg;
    logic              neg_reg;
    logic [3:0]        digs_reg [4];
    logic [2:0]        ndig_reg;
    logic [1:0]        dig_idx_reg;
    logic              rel_reg;
    logic              mv_reg;
    logic [5:0]        key_reg;
    logic              last_reg;

    logic              s_acc;
    logic              emitting;
    logic              load;
    logic [5:0]        key_now;
    logic [IW-1:0]     lim;
    logic [AW-1:0]     rd_addr;
    atk_pkg::entry_t   rd_data;
    atk_pkg::entry_t   wr_data;
    atk_pkg::div_req_t dreq;
    atk_pkg::div_rsp_t drsp;
    logic [9:0]        seg_dist;
    logic [6:0]        step_eff;
    logic signed [11:0] qval;
    logic [26:0]       dig_prod;
    logic [10:0]       dig_q;
    logic [3:0]        dig_r;

    assign s_tready  = (state_reg == atk_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp the searched entry count into 1..depth
    assign lim = (entries_reg == 6'd0) ? IW'(1) :
                 ({1'b0, entries_reg} > 7'(atk_pkg::TABLE_DEPTH)) ? IW'(atk_pkg::TABLE_DEPTH)
                                                                  : IW'(entries_reg);

    assign wr_data.bp   = s_tdata[14:5];
    assign wr_data.temp = s_tdata[22:15];
    assign wr_data.step = s_tdata[29:23];

    assign rd_addr = (state_reg == atk_pkg::ST_SRCH_RD) ? idx_reg[AW-1:0] :
                     (idx_reg == '0) ? '0 : AW'(idx_reg - 1'b1);

    atk_table u_table (
        .clk     (clk),
        .wr_en   (s_acc && s_tuser[0] == atk_pkg::FUNC_LOAD &&
                  {1'b0, s_tdata[4:0]} < 6'(atk_pkg::TABLE_DEPTH)),
        .wr_addr (s_tdata[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // distance to the chosen breakpoint; below the first one it is mirrored
    assign seg_dist = below_reg ? 10'(rd_data.bp - sample_reg) : 10'(sample_reg - rd_data.bp);
    assign step_eff = (rd_data.step == 7'd0) ? 7'd1 : rd_data.step;
    assign qval     = below_reg ? 12'($signed(temp_reg) - $signed({1'b0, drsp.quot}))
                                : 12'($signed(temp_reg) + $signed({1'b0, drsp.quot}));

    // divide the magnitude by ten with a reciprocal multiply, exact for 11 bits
    assign dig_prod = {16'd0, mag_reg} * 27'd52429;
    assign dig_q    = {3'd0, dig_prod[26:19]};
    assign dig_r    = 4'(mag_reg - dig_q * 11'd10);

    always_comb
    begin
        dreq = '0;
        case (state_reg)
            atk_pkg::ST_SEL:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {1'b0, seg_dist};
                dreq.divisor  = step_eff;
            end
            atk_pkg::ST_TEN:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 11'({4'd0, rem1_reg} * 11'd10);
                dreq.divisor  = step_reg;
            end
            default: dreq = '0;
        endcase
    end

    atk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // key for the current emit state; a release follows every key
    always_comb
    begin
        case (state_reg)
            atk_pkg::ST_EM_LEAD: key_now = atk_pkg::KEY_REL;
            atk_pkg::ST_EM_NEG:  key_now = atk_pkg::KEY_DASH;
            atk_pkg::ST_EM_DIG:  key_now = atk_pkg::digit_key(digs_reg[dig_idx_reg]);
            atk_pkg::ST_EM_DOT:  key_now = atk_pkg::KEY_DOT;
            atk_pkg::ST_EM_TEN:  key_now = atk_pkg::digit_key(tenths_reg);
            atk_pkg::ST_EM_ENT:  key_now = atk_pkg::KEY_ENTER;
            default:             key_now = atk_pkg::KEY_REL;
        endcase
        if (rel_reg)
        begin
            key_now = atk_pkg::KEY_REL;
        end
    end

    assign emitting = (state_reg == atk_pkg::ST_EM_LEAD) || (state_reg == atk_pkg::ST_EM_NEG) ||
                      (state_reg == atk_pkg::ST_EM_DIG)  || (state_reg == atk_pkg::ST_EM_DOT) ||
                      (state_reg == atk_pkg::ST_EM_TEN)  || (state_reg == atk_pkg::ST_EM_ENT);
    assign load = emitting && (!mv_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atk_pkg::ST_IDLE:
                if (s_acc && s_tuser[0] == atk_pkg::FUNC_CONVERT)
                begin
                    state_next = raw_cfg_reg ? atk_pkg::ST_DIG : atk_pkg::ST_SRCH_RD;
                end
            atk_pkg::ST_SRCH_RD:
                state_next = atk_pkg::ST_SRCH_CMP;
            atk_pkg::ST_SRCH_CMP:
                if (sample_reg < rd_data.bp || IW'(idx_reg + 1'b1) == lim)
                begin
                    state_next = atk_pkg::ST_SEL_RD;
                end
                else
                begin
                    state_next = atk_pkg::ST_SRCH_RD;
                end
            atk_pkg::ST_SEL_RD:   state_next = atk_pkg::ST_SEL;
            atk_pkg::ST_SEL:      state_next = atk_pkg::ST_Q1_WAIT;
            atk_pkg::ST_Q1_WAIT:  if (drsp.done) state_next = atk_pkg::ST_TEN;
            atk_pkg::ST_TEN:      state_next = atk_pkg::ST_TEN_WAIT;
            atk_pkg::ST_TEN_WAIT: if (drsp.done) state_next = atk_pkg::ST_DIG;
            atk_pkg::ST_DIG:
                state_next = (dig_q == '0) ? atk_pkg::ST_EM_LEAD : atk_pkg::ST_DIG;
            atk_pkg::ST_EM_LEAD:
                if (load && rel_reg)
                begin
                    state_next = neg_reg ? atk_pkg::ST_EM_NEG : atk_pkg::ST_EM_DIG;
                end
            atk_pkg::ST_EM_NEG:
                if (load && rel_reg) state_next = atk_pkg::ST_EM_DIG;
            atk_pkg::ST_EM_DIG:
                if (load && rel_reg && dig_idx_reg == 2'd0)
                begin
                    state_next = raw_reg ? atk_pkg::ST_EM_ENT : atk_pkg::ST_EM_DOT;
                end
            atk_pkg::ST_EM_DOT:
                if (load && rel_reg) state_next = atk_pkg::ST_EM_TEN;
            atk_pkg::ST_EM_TEN:
                if (load && rel_reg) state_next = atk_pkg::ST_EM_ENT;
            atk_pkg::ST_EM_ENT:
                if (load && rel_reg) state_next = atk_pkg::ST_IDLE;
            default: state_next = atk_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= atk_pkg::ST_IDLE;
            entries_reg <= 6'd1;
            raw_cfg_reg <= 1'b0;
            mv_reg      <= 1'b0;
            rel_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index[0] == atk_pkg::CFG_ENTRIES)
                begin
                    entries_reg <= cfg_data;
                end
                else
                begin
                    raw_cfg_reg <= cfg_data[0];
                end
            end
            if (load)
            begin
                mv_reg  <= 1'b1;
                rel_reg <= !rel_reg;
            end
            else if (m_tready)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= key_now;
            last_reg <= rel_reg && (state_reg == atk_pkg::ST_EM_ENT);
        end
        case (state_reg)
            atk_pkg::ST_IDLE:
            begin
                sample_reg <= s_tdata[39:30];
                raw_reg    <= raw_cfg_reg;
                idx_reg    <= '0;
                mag_reg    <= {1'b0, s_tdata[39:30]};
                neg_reg    <= 1'b0;
                ndig_reg   <= '0;
            end
            atk_pkg::ST_SRCH_CMP:
            begin
                // stop at the first breakpoint above the sample, or at the last searched entry
                below_reg <= 1'b0;
                if (sample_reg < rd_data.bp)
                begin
                    below_reg <= (idx_reg == '0);
                end
                else if (IW'(idx_reg + 1'b1) != lim)
                begin
                    idx_reg <= IW'(idx_reg + 1'b1);
                end
                else
                begin
                    idx_reg <= lim;
                end
            end
            atk_pkg::ST_SEL_RD:
                ;
            atk_pkg::ST_SEL:
            begin
                temp_reg <= rd_data.temp;
                step_reg <= step_eff;
            end
            atk_pkg::ST_Q1_WAIT:
                if (drsp.done)
                begin
                    rem1_reg <= drsp.rem;
                    neg_reg  <= qval[11];
                    mag_reg  <= qval[11] ? 11'(-qval) : qval[10:0];
                end
            atk_pkg::ST_TEN_WAIT:
                if (drsp.done) tenths_reg <= drsp.quot[3:0];
            atk_pkg::ST_DIG:
            begin
                digs_reg[ndig_reg[1:0]] <= dig_r;
                ndig_reg    <= ndig_reg + 1'b1;
                dig_idx_reg <= ndig_reg[1:0];
                mag_reg     <= dig_q;
            end
            atk_pkg::ST_EM_DIG:
                if (load && rel_reg && dig_idx_reg != 2'd0)
                begin
                    dig_idx_reg <= dig_idx_reg - 1'b1;
                end
            default:
                ;
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, key_reg};
    assign m_tlast  = last_reg;
endmodule
`default_nettype wire

@@ rtl/core/atk_checker.sv @@
// Port-level checks for adc_to_temperature_keystrokes, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module atk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("convert word did not hold the input");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("key code pad bits set");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[5:0] == 6'd0)
        else $error("final word is not a release");
endmodule

bind adc_to_temperature_keystrokes atk_checker u_atk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ bench/adc_to_temperature_keystrokes_test.sv @@
// Self-checking bench for adc_to_temperature_keystrokes: table loads, conversions
// and raw mode checked key by key. Depends on atk_pkg and the RTL top only.
`default_nettype none

class keystroke_scoreboard;
    typedef struct {
        logic [5:0] code;
        logic       last;
    } key_t;

    atk_pkg::entry_t cal_table [atk_pkg::TABLE_DEPTH];
    bit              written [atk_pkg::TABLE_DEPTH];
    int              entries_reg;
    bit              raw_reg;
    key_t            pending_keys [$];
    int              mismatches;
    int              converts;
    int              loads;
    int              keys_seen;

    function void clear();
        entries_reg = 1;
        raw_reg     = 0;
        mismatches  = 0;
        foreach (written[i]) written[i] = 0;
    endfunction

    // Largest number of table entries the search walks.
    function int searched();
        int c;
        c = entries_reg;
        if (c < 1) c = 1;
        if (c > atk_pkg::TABLE_DEPTH) c = atk_pkg::TABLE_DEPTH;
        return c;
    endfunction

    function bit prefix_ready();
        for (int i = 0; i < searched(); i++)
            if (!written[i]) return 0;
        return 1;
    endfunction

    function int first_unwritten();
        for (int i = 0; i < atk_pkg::TABLE_DEPTH; i++)
            if (!written[i]) return i;
        return 0;
    endfunction

    function void write_reg(logic idx, logic [5:0] value);
        if (idx == atk_pkg::CFG_ENTRIES) entries_reg = value;
        else raw_reg = value[0];
    endfunction

    function void push_key(logic [5:0] code);
        key_t k;
        k.code = code;
        k.last = 0;
        pending_keys.push_back(k);
        k.code = atk_pkg::KEY_REL;
        pending_keys.push_back(k);
    endfunction

    function logic [5:0] digit_code(int d);
        return d == 0 ? atk_pkg::KEY_ZERO : 6'(atk_pkg::KEY_ONE + d - 1);
    endfunction

    function void push_number(int v);
        int mag;
        int digs [$];
        if (v < 0)
        begin
            push_key(atk_pkg::KEY_DASH);
            mag = -v;
        end
        else
            mag = v;
        do
        begin
            digs.push_front(mag % 10);
            mag = mag / 10;
        end while (mag != 0);
        foreach (digs[i]) push_key(digit_code(digs[i]));
    endfunction

    // Note one accepted input word and queue the keys it must produce.
    function void note_word(logic func, logic [39:0] data);
        int  smp, idx, seg_dist, stp, quot, n;
        bit  below;
        key_t k;
        atk_pkg::entry_t e;
        if (func == atk_pkg::FUNC_LOAD)
        begin
            idx = data[4:0];
            cal_table[idx] = {data[14:5], data[22:15], data[29:23]};
            written[idx] = 1;
            loads++;
            return;
        end
        converts++;
        smp = data[39:30];
        k.code = atk_pkg::KEY_REL;
        k.last = 0;
        pending_keys.push_back(k);
        pending_keys.push_back(k);
        if (raw_reg)
            push_number(smp);
        else
        begin
            n = searched();
            idx = 0;
            while (idx < n && smp >= int'(cal_table[idx].bp)) idx++;
            below = (idx == 0);
            e = below ? cal_table[0] : cal_table[idx - 1];
            seg_dist = below ? int'(e.bp) - smp : smp - int'(e.bp);
            stp = (e.step == 0) ? 1 : int'(e.step);
            quot = below ? int'($signed(e.temp)) - seg_dist / stp
                         : int'($signed(e.temp)) + seg_dist / stp;
            push_number(quot);
            push_key(atk_pkg::KEY_DOT);
            push_key(digit_code((10 * (seg_dist % stp)) / stp));
        end
        push_key(atk_pkg::KEY_ENTER);
        pending_keys[$].last = 1;
    endfunction

    function void check_key(logic [5:0] code, logic last);
        key_t k;
        keys_seen++;
        if (pending_keys.size() == 0)
        begin
            $error("unexpected key word: key_code %0d last_key %0d", code, last);
            mismatches++;
            return;
        end
        k = pending_keys.pop_front();
        if (code !== k.code)
        begin
            $error("key_code: expected %0d, got %0d", k.code, code);
            mismatches++;
        end
        if (last !== k.last)
        begin
            $error("last_key: expected %0d, got %0d", k.last, last);
            mismatches++;
        end
    endfunction
endclass

module adc_to_temperature_keystrokes_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Post-convert quiet time; covers search, divider passes and emission.
    localparam int SETTLE_CYCLES = 300;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // slot[4:0] bp[14:5] temp[22:15] step[29:23] sample[39:30]
    logic [0:0]  s_tuser = '0;    // func[0]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;         // key_code[5:0], zero [7:6]
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;

    keystroke_scoreboard keys = new();
    bit quiet = 0;    // no idling on either side once set

    adc_to_temperature_keystrokes DUT (.*);

    always #2 clk = ~clk;

    // Receiver: stall in random bursts unless quiet.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready <= 0;
        end
        else
            m_tready <= 1;
    end

    // Output monitor: compare every accepted key word.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            keys.check_key(m_tdata[5:0], m_tlast);

    // Hold a word on the slave side until accepted; valid stays high afterwards.
    task automatic send_word(logic func, logic [39:0] data);
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        keys.note_word(func, data);
    endtask

    // Drop valid for a random burst, sometimes.
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_load(int slot, int bp, int temp, int stp);
        send_word(atk_pkg::FUNC_LOAD, {10'd0, 7'(stp), 8'(temp), 10'(bp), 5'(slot)});
    endtask

    task automatic send_convert(int smp);
        send_word(atk_pkg::FUNC_CONVERT, {10'(smp), 30'd0});
    endtask

    // Wait for all keys to drain, then give the block time to go idle.
    task automatic settle();
        s_tvalid <= 0;
        while (keys.pending_keys.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drop valid after the write and hold it low for one cycle.
    task automatic write_reg(logic idx, int value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= 6'(value);
        do @(posedge clk); while (!cfg_ready);
        keys.write_reg(idx, 6'(value));
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Random load; half the time keep breakpoints ascending by slot so the
    // search walks through a proper piecewise table.
    task automatic random_load(int slot);
        int bp;
        bp = ($urandom_range(0, 1) == 0) ? slot * 32 + $urandom_range(0, 31)
                                         : $urandom_range(0, 1023);
        send_load(slot, bp, $urandom_range(0, 255), $urandom_range(0, 127));
    endtask

    task automatic random_phase(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                random_load($urandom_range(0, 31));
            else if (!keys.raw_reg && !keys.prefix_ready())
                random_load(keys.first_unwritten());   // never search an unwritten entry
            else
                send_convert($urandom_range(0, 1023));
            maybe_gap();
        end
    endtask

    initial
    begin
        keys.clear();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes of temperature, step and sample with one entry.
        send_load(0, 512, -128, 1);
        send_convert(0);            // below the first breakpoint, negative
        send_convert(1023);
        send_convert(512);          // exactly on the breakpoint
        send_load(0, 100, 127, 127);
        send_convert(1023);
        send_convert(0);            // below: fraction keeps its positive sense
        send_load(0, 0, 5, 0);      // zero step acts as one
        send_convert(1023);
        send_load(1, 1023, -1, 3);
        send_load(2, 300, 0, 7);
        settle();
        write_reg(atk_pkg::CFG_ENTRIES, 3);
        send_convert(1023);
        send_convert(500);
        send_convert(299);
        settle();
        write_reg(atk_pkg::CFG_RAW, 1);
        send_convert(0);
        send_convert(1023);
        send_convert(7);
        settle();
        write_reg(atk_pkg::CFG_RAW, 0);
        write_reg(atk_pkg::CFG_ENTRIES, 0);  // acts as one entry
        send_convert(40);

        // Random phases across register settings, extremes included.
        begin
            int entries_set [8] = '{2, 63, 17, 32, 1, 0, 9, 32};
            foreach (entries_set[p])
            begin
                settle();
                write_reg(atk_pkg::CFG_ENTRIES, entries_set[p]);
                write_reg(atk_pkg::CFG_RAW, ($urandom_range(0, 3) == 0));
                if (p == 7) quiet = 1;
                random_phase(44);
            end
        end

        settle();
        $display("Covered %0d loads and %0d conversions, %0d key words checked.",
                 keys.loads, keys.converts, keys.keys_seen);
        if (keys.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Timeout waiting for the block");
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
